### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge out of reset.
`define AHIST_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition leads to another in the next cycle.
`define AHIST_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/ahist_pkg.sv
// ----------------------------------------------------------------------------
// ahist_pkg
// Sizes, request and register codes and helpers of the axis histogram.
// ----------------------------------------------------------------------------
package ahist_pkg;

	localparam int unsigned MAX_BINS      = 1024;
	localparam int unsigned POS_FRAC_BITS = 16;
	localparam int unsigned INV_FRAC_BITS = 16;
	localparam int unsigned BIN_SHIFT     = POS_FRAC_BITS + INV_FRAC_BITS;
	localparam int unsigned BIN_W         = $clog2(MAX_BINS);
	localparam int unsigned NUM_AXES      = 3;
	localparam int unsigned CNT_W         = 32;
	localparam int unsigned POS_W         = 32;
	localparam int unsigned PROD_W        = 64;
	localparam int unsigned BINS_CFG_W    = 11;
	localparam int unsigned DENS_W        = 48;
	localparam int unsigned VOL_SHIFT     = 16;
	localparam int unsigned CFG_IDX_W     = 3;
	localparam int unsigned CFG_DATA_W    = 32;

	typedef logic [BIN_W-1:0]      bin_t;
	typedef logic [BIN_W:0]        bins_t;
	typedef logic [CNT_W-1:0]      cnt_t;
	typedef logic [BINS_CFG_W-1:0] bins_cfg_t;

	// request codes
	localparam logic [1:0] REQ_CLEAR = 2'd0;
	localparam logic [1:0] REQ_ADD   = 2'd1;
	localparam logic [1:0] REQ_READ  = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_INV_BIN_WIDTH = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BINS_X        = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BINS_Y        = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_BINS_Z        = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_INV_VOL_X     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_INV_VOL_Y     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_INV_VOL_Z     = 3'd6;

	// Bins in use: zero counts as one, anything above the store depth as the depth.
	function automatic bins_t bins_eff(bins_cfg_t n);
		if (n == '0) begin
			return bins_t'(1);
		end
		if (32'(n) > 32'(MAX_BINS)) begin
			return bins_t'(MAX_BINS);
		end
		return bins_t'(n);
	endfunction

	// Increment a count, holding at all ones.
	function automatic cnt_t sat_inc(cnt_t c);
		if (c == '1) begin
			return c;
		end
		return c + cnt_t'(1);
	endfunction

endpackage

### sv/ahist_req_if.sv
// ----------------------------------------------------------------------------
// ahist_req_if
// Request channel: clear, add particle or read bin.
// ----------------------------------------------------------------------------
interface ahist_req_if import ahist_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [1:0]       req_type;
	logic [POS_W-1:0] pos_x;
	logic [POS_W-1:0] pos_y;
	logic [POS_W-1:0] pos_z;
	logic [1:0]       axis;
	logic [9:0]       bin_index;

	modport source (output valid, req_type, pos_x, pos_y, pos_z, axis, bin_index,
		input ready);
	modport sink (input valid, req_type, pos_x, pos_y, pos_z, axis, bin_index,
		output ready);
endinterface

### sv/ahist_rsp_if.sv
// ----------------------------------------------------------------------------
// ahist_rsp_if
// Result channel: density and raw count of one read bin.
// ----------------------------------------------------------------------------
interface ahist_rsp_if import ahist_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [DENS_W-1:0] density;
	logic [CNT_W-1:0]  bin_count;

	modport source (output valid, density, bin_count, input ready);
	modport sink (input valid, density, bin_count, output ready);
endinterface

### sv/ahist_cfg_if.sv
// ----------------------------------------------------------------------------
// ahist_cfg_if
// Register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface ahist_cfg_if import ahist_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### sv/axis_density_histogram_core.sv
// ----------------------------------------------------------------------------
// axis_density_histogram_core
// Three per-axis bin-count histograms with density readout.
// ----------------------------------------------------------------------------
// Each axis keeps its counts in a MAX_BINS x 32 synchronous RAM. Requests are
// handled one at a time: an add steps through the multiply, the read and the
// write back of the saturated increment in all three RAMs at once; a read
// steps through the RAM read, count times reciprocal volume and the load of
// the output register, plus any wait for the output register to free up. A
// clear, and the pass that follows reset, sweep every RAM address once,
// during which no request is taken; register writes are taken at any time.
// The result sits in an output register, so adds keep flowing while it waits.
`include "assert_macros.svh"

module axis_density_histogram_core import ahist_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	ahist_req_if.sink   req,
	ahist_rsp_if.source rsp,
	ahist_cfg_if.sink   cfg
);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_BIN,
		ST_WB,
		ST_RD,
		ST_OUT
	} state_t;

	localparam bin_t CLR_LAST = bin_t'(MAX_BINS - 1);

	state_t            state_q;
	bin_t              clr_cnt_q;
	logic [31:0]       inv_bin_width_q;
	bins_cfg_t         bins_q    [NUM_AXES];
	logic [31:0]       inv_vol_q [NUM_AXES];
	bins_t             eff       [NUM_AXES];
	bin_t              top_bin   [NUM_AXES];
	logic [POS_W-1:0]  pos_a     [NUM_AXES];
	bin_t              bin_c     [NUM_AXES];
	bin_t              bin_s2    [NUM_AXES];
	cnt_t              rdata     [NUM_AXES];
	cnt_t              wdata_a   [NUM_AXES];
	logic              req_acc;
	logic              add_acc;
	logic              rd_ok_c;
	logic              rd_ok_s1;
	logic [1:0]        axis_s1;
	cnt_t              cnt_c;
	logic [31:0]       vol_c;
	cnt_t              cnt_s2;
	logic [PROD_W-1:0] prod_s2;
	logic              out_load;
	logic              out_valid_q;
	logic [DENS_W-1:0] density_q;
	cnt_t              count_q;

	// register writes
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_bin_width_q <= 32'd65536;
			for (int a = 0; a < NUM_AXES; a++) begin
				bins_q[a]    <= bins_cfg_t'(1024);
				inv_vol_q[a] <= '0;
			end
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_INV_BIN_WIDTH: inv_bin_width_q <= cfg.data;
				CFG_BINS_X:        bins_q[0]       <= cfg.data[BINS_CFG_W-1:0];
				CFG_BINS_Y:        bins_q[1]       <= cfg.data[BINS_CFG_W-1:0];
				CFG_BINS_Z:        bins_q[2]       <= cfg.data[BINS_CFG_W-1:0];
				CFG_INV_VOL_X:     inv_vol_q[0]    <= cfg.data;
				CFG_INV_VOL_Y:     inv_vol_q[1]    <= cfg.data;
				CFG_INV_VOL_Z:     inv_vol_q[2]    <= cfg.data;
				default: ;
			endcase
		end
	end

	// handshake
	assign req.ready = (state_q == ST_IDLE);
	assign req_acc   = req.valid && req.ready;
	assign add_acc   = req_acc && (req.req_type == REQ_ADD);

	assign pos_a[0] = req.pos_x;
	assign pos_a[1] = req.pos_y;
	assign pos_a[2] = req.pos_z;

	// per-axis bin unit and count RAM
	for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
		assign eff[a]     = bins_eff(bins_q[a]);
		assign top_bin[a] = bin_t'(eff[a] - bins_t'(1));
		assign wdata_a[a] = (state_q == ST_CLEAR) ? '0 : sat_inc(rdata[a]);

		ahist_binner u_binner (
			.clk           (clk),
			.load          (add_acc),
			.pos           (pos_a[a]),
			.inv_bin_width (inv_bin_width_q),
			.top           (top_bin[a]),
			.bin           (bin_c[a])
		);

		ahist_ram #(
			.DEPTH (MAX_BINS),
			.WIDTH (CNT_W)
		) u_ram (
			.clk   (clk),
			.we    ((state_q == ST_CLEAR) || (state_q == ST_WB)),
			.waddr ((state_q == ST_CLEAR) ? clr_cnt_q : bin_s2[a]),
			.wdata (wdata_a[a]),
			.raddr ((state_q == ST_BIN) ? bin_c[a] : bin_t'(req.bin_index)),
			.rdata (rdata[a])
		);
	end

	// read request in range: real axis and bin below bins in use
	always_comb begin
		rd_ok_c = 1'b0;
		for (int a = 0; a < NUM_AXES; a++) begin
			if (req.axis == 2'(a) && 32'(req.bin_index) < 32'(eff[a])) begin
				rd_ok_c = 1'b1;
			end
		end
	end

	// select count and reciprocal volume of the read axis
	always_comb begin
		cnt_c = '0;
		vol_c = '0;
		for (int a = 0; a < NUM_AXES; a++) begin
			if (rd_ok_s1 && axis_s1 == 2'(a)) begin
				cnt_c = rdata[a];
				vol_c = inv_vol_q[a];
			end
		end
	end

	// load the output register once it is free or being drained
	assign out_load = (state_q == ST_OUT) && (!out_valid_q || rsp.ready);

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_cnt_q   <= '0;
			rd_ok_s1    <= 1'b0;
			axis_s1     <= '0;
			out_valid_q <= 1'b0;
			density_q   <= '0;
			count_q     <= '0;
			cnt_s2      <= '0;
			prod_s2     <= '0;
			for (int a = 0; a < NUM_AXES; a++) begin
				bin_s2[a] <= '0;
			end
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
				density_q   <= prod_s2[VOL_SHIFT +: DENS_W];
				count_q     <= cnt_s2;
			end else if (out_valid_q && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + bin_t'(1);
					if (clr_cnt_q == CLR_LAST) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (req_acc) begin
						unique case (req.req_type)
							REQ_CLEAR: begin
								clr_cnt_q <= '0;
								state_q   <= ST_CLEAR;
							end
							REQ_ADD: state_q <= ST_BIN;
							REQ_READ: begin
								axis_s1  <= req.axis;
								rd_ok_s1 <= rd_ok_c;
								state_q  <= ST_RD;
							end
							default: ;
						endcase
					end
				end
				ST_BIN: begin
					for (int a = 0; a < NUM_AXES; a++) begin
						bin_s2[a] <= bin_c[a];
					end
					state_q <= ST_WB;
				end
				ST_WB: state_q <= ST_IDLE;
				ST_RD: begin
					cnt_s2  <= cnt_c;
					prod_s2 <= PROD_W'(cnt_c) * PROD_W'(vol_c);
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.density   = density_q;
	assign rsp.bin_count = count_q;

	// checks
	`AHIST_ASSERT(a_wb_nonzero, state_q != ST_WB || (wdata_a[0] != '0 && wdata_a[1] != '0 && wdata_a[2] != '0), "write-back of a zero count")
	`AHIST_ASSERT(a_bin_in_use, state_q != ST_BIN || (bins_t'(bin_c[0]) < eff[0] && bins_t'(bin_c[1]) < eff[1] && bins_t'(bin_c[2]) < eff[2]), "bin beyond bins in use")
	`AHIST_ASSERT_NEXT(a_clear_sweep, state_q == ST_CLEAR && clr_cnt_q != CLR_LAST, state_q == ST_CLEAR, "clear sweep cut short")
	`AHIST_ASSERT(a_out_src, !$rose(out_valid_q) || $past(state_q) == ST_OUT, "result raised outside output step")

endmodule

### sv/ahist_ram.sv
// ----------------------------------------------------------------------------
// ahist_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ahist_ram #(
	parameter int unsigned DEPTH = 1024,
	parameter int unsigned WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

### sv/ahist_binner.sv
// ----------------------------------------------------------------------------
// ahist_binner
// Bin of one coordinate: registered product of position and reciprocal bin
// width, floored and clamped to the last bin in use.
// ----------------------------------------------------------------------------
module ahist_binner import ahist_pkg::*; (
	input  logic             clk,
	input  logic             load,
	input  logic [POS_W-1:0] pos,
	input  logic [31:0]      inv_bin_width,
	input  bin_t             top,
	output bin_t             bin
);

	logic [PROD_W-1:0] prod_s1;
	logic [PROD_W-1:0] bin_raw;

	// multiply on accept
	always_ff @(posedge clk) begin
		if (load) begin
			prod_s1 <= PROD_W'(pos) * PROD_W'(inv_bin_width);
		end
	end

	// floor and clamp
	always_comb begin
		bin_raw = prod_s1 >> BIN_SHIFT;
		if (bin_raw > PROD_W'(top)) begin
			bin = top;
		end else begin
			bin = bin_t'(bin_raw);
		end
	end

endmodule
